// ===== hdl/qat_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qat_pkg
// Shared types and character codes for the quoted argument tokenizer.
// ----------------------------------------------------------------------------
package qat_pkg;

    // Character codes that the scanner reacts to.
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_LOWER_N  = 8'h6E;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;

    // Stream widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 2;

    // One command line byte.
    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_line;
    } item_t;

    // One result.
    typedef struct packed {
        logic [3:0] arg_index;
        logic [7:0] out_byte;
        logic       has_byte;
        logic       token_end;
        logic       line_done;
        logic [4:0] arg_count;
    } result_t;

endpackage : qat_pkg
`default_nettype wire

// ===== hdl/qat_in_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qat_in_stage
// Input register: holds one accepted byte until the scanner consumes it.
// ----------------------------------------------------------------------------
module qat_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire qat_pkg::item_t in_item,
    input  wire logic          consume,
    output logic               item_valid,
    output qat_pkg::item_t     item
);
    import qat_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Take a new item when empty or when the held one moves on this cycle.
    assign in_ready   = !valid_reg || consume;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule : qat_in_stage
`default_nettype wire

// ===== hdl/qat_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qat_core
// Scanner state machine: mode, token length and token count, with the
// combinational decode of one byte into at most one result.
// ----------------------------------------------------------------------------
module qat_core #(
    parameter int MAX_ARGS    = 16,
    parameter int TOKEN_BYTES = 256
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    input  wire qat_pkg::item_t  item,
    input  wire logic            out_free,
    output logic                 consume,
    output logic                 res_valid,
    output qat_pkg::result_t     res
);
    import qat_pkg::*;

    localparam int LEN_W = (TOKEN_BYTES > 2) ? $clog2(TOKEN_BYTES) : 1;
    localparam int CNT_W = $clog2(MAX_ARGS + 1);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(TOKEN_BYTES - 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_ARGS);

    typedef enum logic [2:0] {
        MODE_BETWEEN   = 3'd0,
        MODE_UNQUOTED  = 3'd1,
        MODE_QUOTED    = 3'd2,
        MODE_ESCAPE    = 3'd3,
        MODE_AFTER_CUT = 3'd4,
        MODE_FULL      = 3'd5
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             produce;
    result_t          res_c;
    logic             eol;
    logic [CNT_W-1:0] cnt_inc;

    assign eol     = item.end_of_line || (item.char_byte == CH_NUL);
    assign cnt_inc = cnt_reg + CNT_W'(1);

    // Decode one byte against the current mode.
    always_comb
    begin
        logic             do_emit;
        logic [7:0]       emit_val;
        logic [LEN_W-1:0] emit_len;
        mode_t            cut_mode;
        mode_t            stay_mode;
        logic             tok_open;

        do_emit   = 1'b0;
        emit_val  = item.char_byte;
        emit_len  = len_reg + LEN_W'(1);
        cut_mode  = MODE_BETWEEN;
        stay_mode = MODE_UNQUOTED;
        tok_open  = 1'b0;
        produce   = 1'b0;
        res_c     = '0;
        mode_next = mode_reg;
        len_next  = len_reg;
        cnt_next  = cnt_reg;

        if (eol)
        begin
            // End of line closes any open token and reports the count.
            tok_open = (mode_reg == MODE_UNQUOTED) || (mode_reg == MODE_QUOTED) ||
                       (mode_reg == MODE_ESCAPE);
            produce         = 1'b1;
            res_c.line_done = 1'b1;
            if (tok_open)
            begin
                res_c.arg_index = 4'(cnt_reg);
                res_c.token_end = 1'b1;
                res_c.arg_count = 5'(cnt_inc);
                if (mode_reg == MODE_ESCAPE)
                begin
                    res_c.out_byte = CH_BSLASH;
                    res_c.has_byte = 1'b1;
                end
            end
            else
            begin
                res_c.arg_count = 5'(cnt_reg);
            end
            mode_next = MODE_BETWEEN;
            len_next  = '0;
            cnt_next  = '0;
        end
        else
        begin
            case (mode_reg)
                MODE_FULL:
                begin
                    mode_next = MODE_FULL;
                end
                MODE_BETWEEN, MODE_AFTER_CUT:
                begin
                    if (mode_reg == MODE_AFTER_CUT && item.char_byte == CH_QUOTE)
                    begin
                        mode_next = MODE_BETWEEN;
                    end
                    else if (item.char_byte == CH_SPACE)
                    begin
                        mode_next = MODE_BETWEEN;
                    end
                    else if (item.char_byte == CH_QUOTE)
                    begin
                        mode_next = MODE_QUOTED;
                        len_next  = '0;
                    end
                    else
                    begin
                        // A new unquoted token starts with this byte.
                        do_emit  = 1'b1;
                        emit_len = LEN_W'(1);
                    end
                end
                MODE_UNQUOTED:
                begin
                    if (item.char_byte == CH_SPACE)
                    begin
                        produce         = 1'b1;
                        res_c.arg_index = 4'(cnt_reg);
                        res_c.token_end = 1'b1;
                        cnt_next        = cnt_inc;
                        len_next        = '0;
                        mode_next       = (cnt_inc >= CNT_LIMIT) ? MODE_FULL : MODE_BETWEEN;
                    end
                    else
                    begin
                        do_emit = 1'b1;
                    end
                end
                MODE_QUOTED:
                begin
                    if (item.char_byte == CH_QUOTE)
                    begin
                        produce         = 1'b1;
                        res_c.arg_index = 4'(cnt_reg);
                        res_c.token_end = 1'b1;
                        cnt_next        = cnt_inc;
                        len_next        = '0;
                        mode_next       = (cnt_inc >= CNT_LIMIT) ? MODE_FULL : MODE_BETWEEN;
                    end
                    else if (item.char_byte == CH_BSLASH)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else
                    begin
                        do_emit   = 1'b1;
                        cut_mode  = MODE_AFTER_CUT;
                        stay_mode = MODE_QUOTED;
                    end
                end
                MODE_ESCAPE:
                begin
                    // Backslash-n is a newline; any other escaped byte is literal.
                    do_emit   = 1'b1;
                    cut_mode  = MODE_AFTER_CUT;
                    stay_mode = MODE_QUOTED;
                    if (item.char_byte == CH_LOWER_N)
                    begin
                        emit_val = CH_NEWLINE;
                    end
                end
                default:
                begin
                    mode_next = MODE_BETWEEN;
                    len_next  = '0;
                    cnt_next  = '0;
                end
            endcase

            // Append one byte, cutting the token when it reaches its limit.
            if (do_emit)
            begin
                produce         = 1'b1;
                res_c.arg_index = 4'(cnt_reg);
                res_c.out_byte  = emit_val;
                res_c.has_byte  = 1'b1;
                if (emit_len >= LEN_LIMIT)
                begin
                    res_c.token_end = 1'b1;
                    cnt_next        = cnt_inc;
                    len_next        = '0;
                    mode_next       = (cnt_inc >= CNT_LIMIT) ? MODE_FULL : cut_mode;
                end
                else
                begin
                    len_next  = emit_len;
                    mode_next = stay_mode;
                end
            end
        end
    end

    // An item moves on when the result register can take its result, or
    // when it gives no result at all.
    assign consume   = item_valid && (out_free || !produce);
    assign res_valid = item_valid && produce && out_free;
    assign res       = res_c;

    // Scanner state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BETWEEN;
            len_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (consume)
        begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            cnt_reg  <= cnt_next;
        end
    end

    // The token count never passes the argument limit.
    a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_LIMIT)
        else $error("token count above argument limit");

    // Full mode is entered only once the limit is reached.
    a_full_count : assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_FULL) |-> (cnt_reg == CNT_LIMIT))
        else $error("full mode with count below limit");

    // A consumed end of line returns the scanner to its reset state.
    a_eol_reset : assert property (@(posedge clk) disable iff (!rst_n)
        (consume && eol) |=> (mode_reg == MODE_BETWEEN && cnt_reg == '0 && len_reg == '0))
        else $error("scanner state not cleared after end of line");

    // A result without a byte carries a zero byte.
    a_zero_byte : assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.has_byte) |-> (res.out_byte == 8'h00))
        else $error("byte present on result without has_byte");

endmodule : qat_core
`default_nettype wire

// ===== hdl/qat_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qat_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module qat_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire qat_pkg::result_t res,
    output logic                  out_free,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output qat_pkg::result_t      out_res
);
    import qat_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // Free when empty or when the held result leaves this cycle.
    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule : qat_out_stage
`default_nettype wire

// ===== hdl/quoted_argument_tokenizer.sv =====
`default_nettype none
// Each byte passes the input register and the scanner into the result register on m_tdata.
// Throughput: one byte per cycle while m_tready stays high; one mode and counter
// update in the scanner between the input register and the result register.
// Bytes that give no result (opening quote, skipped space, escape start, ignored
// bytes) move on even while a result waits. Reset clears both stages and puts the
// scanner between tokens with zero length and count; no clearing pass is needed.
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer
// Splits a command line, one byte per item, into space separated and
// double quoted arguments, one result byte at a time.
// ----------------------------------------------------------------------------
module quoted_argument_tokenizer #(
    parameter int MAX_ARGS    = 16,
    parameter int TOKEN_BYTES = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [qat_pkg::IN_TDATA_W-1:0]     s_tdata,  // char_byte[7:0]
    input  wire logic                               s_tlast,  // end_of_line
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [qat_pkg::OUT_TDATA_W-1:0]         m_tdata,  // arg_index[3:0],
                                                              // out_byte[11:4],
                                                              // arg_count[16:12]
    output logic [qat_pkg::OUT_TUSER_W-1:0]         m_tuser,  // has_byte[0],
                                                              // token_end[1]
    output logic                                    m_tlast   // line_done
);
    import qat_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    consume;
    logic    out_free;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign in_item.char_byte   = s_tdata;
    assign in_item.end_of_line = s_tlast;

    // Input register.
    qat_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .consume    (consume),
        .item_valid (item_valid),
        .item       (item)
    );

    // Scanner.
    qat_core #(
        .MAX_ARGS    (MAX_ARGS),
        .TOKEN_BYTES (TOKEN_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .consume    (consume),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Result register.
    qat_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack the result onto the stream.
    assign m_tdata = {7'b0, out_res.arg_count, out_res.out_byte, out_res.arg_index};
    assign m_tuser = {out_res.token_end, out_res.has_byte};
    assign m_tlast = out_res.line_done;

endmodule : quoted_argument_tokenizer
`default_nettype wire
